// ===== src/deq_pkg.sv =====
// Shared types, field widths and operation codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
  } deq_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] item;
    logic [FILL_W-1:0]        fill;
    logic                     last;
  } deq_res_t;

  typedef struct packed {
    logic we;
    logic re;
  } deq_mem_ctl_t;

endpackage

// ===== src/deq_ring_add.sv =====
// Shared ring address unit: base plus offset, wrapped at the store capacity.
`timescale 1ns / 1ps

module deq_ring_add #(
  parameter int Capacity = 16,
  parameter int IdxW     = 4
) (
  input  logic [IdxW-1:0] base_i,
  input  logic [IdxW-1:0] off_i,
  output logic [IdxW-1:0] sum_o
);

  localparam logic [IdxW:0] CapW = (IdxW+1)'(Capacity);

  logic [IdxW:0] raw;
  logic [IdxW:0] wrapped;

  assign raw     = {1'b0, base_i} + {1'b0, off_i};
  assign wrapped = raw - CapW;
  assign sum_o   = (raw >= CapW) ? wrapped[IdxW-1:0] : raw[IdxW-1:0];

endmodule

// ===== src/deq_store.sv =====
// Single-port ring store with registered read data.
`timescale 1ns / 1ps

module deq_store
  import deq_pkg::*;
#(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                     clk_i,
  input  deq_mem_ctl_t             ctl_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [Depth];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/double_ended_queue_top.sv =====
// Double-ended queue top level: operation sequencer around a ring store.
// Push: execute state, then the store-access state issues one result strobe.
// Pop: execute, store-access, then the emit state issues the result.
// Dump: emit state gives the first value; store-access and emit then alternate.
// Busy stays high until the final result is issued; start is taken again then.
// Reset empties the queue and clears the front index; store contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  deq_cmd_t cmd_i,
  output logic     res_valid_o,
  output deq_res_t res_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MEM,
    S_EMIT
  } state_e;

  state_e                   state_q;
  deq_cmd_t                 cmd_q;
  logic [IW-1:0]            front_q;
  logic [OW-1:0]            occ_q;
  logic [IW-1:0]            addr_q;
  logic [IW-1:0]            cnt_q;
  logic                     res_valid_q;
  deq_res_t                 res_q;

  logic [IW-1:0]            alu_off;
  logic [IW-1:0]            alu_sum;
  deq_mem_ctl_t             mem_ctl;
  logic signed [DATA_W-1:0] rdata;
  logic                     is_push;
  logic                     is_pop;
  logic                     full;
  logic                     empty;
  logic [OW-1:0]            cnt_next;
  logic                     dump_done;

  assign is_push   = (cmd_q.func == FN_PUSH_FRONT) || (cmd_q.func == FN_PUSH_BACK);
  assign is_pop    = (cmd_q.func == FN_POP_FRONT) || (cmd_q.func == FN_POP_BACK);
  assign full      = (occ_q == OW'(CAPACITY));
  assign empty     = (occ_q == '0);
  assign cnt_next  = OW'(cnt_q) + OW'(1);
  assign dump_done = (cnt_next == occ_q);

  always_comb begin
    alu_off = '0;
    case (state_q)
      S_EXEC: begin
        case (cmd_q.func)
          FN_PUSH_FRONT: alu_off = IW'(CAPACITY - 1);
          FN_PUSH_BACK:  alu_off = occ_q[IW-1:0];
          FN_POP_BACK:   alu_off = IW'(occ_q - OW'(1));
          default:       alu_off = '0;
        endcase
      end
      S_MEM:   alu_off = IW'(1);
      S_EMIT:  alu_off = cnt_q + IW'(1);
      default: alu_off = '0;
    endcase
  end

  deq_ring_add #(
    .Capacity(CAPACITY),
    .IdxW    (IW)
  ) u_ring_add (
    .base_i(front_q),
    .off_i (alu_off),
    .sum_o (alu_sum)
  );

  always_comb begin
    mem_ctl.we = (state_q == S_MEM) && is_push;
    mem_ctl.re = (state_q == S_MEM) && !is_push;
  end

  deq_store #(
    .Depth(CAPACITY),
    .AddrW(IW)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (addr_q),
    .wdata_i(cmd_q.value),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      front_q     <= '0;
      occ_q       <= '0;
      addr_q      <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_q  <= '0;
          addr_q <= alu_sum;
          if (!is_push && !is_pop && (cmd_q.func != FN_DUMP)) begin
            state_q <= S_IDLE;
          end else if (is_push && full) begin
            res_valid_q <= 1'b1;
            res_q       <= '{status: ST_FULL, item: '0, fill: FILL_W'(occ_q), last: 1'b1};
            state_q     <= S_IDLE;
          end else if (!is_push && empty) begin
            res_valid_q <= 1'b1;
            res_q       <= '{status: ST_EMPTY, item: '0, fill: FILL_W'(occ_q), last: 1'b1};
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_MEM;
          end
        end
        S_MEM: begin
          if (is_push) begin
            if (cmd_q.func == FN_PUSH_FRONT) begin
              front_q <= addr_q;
            end
            occ_q       <= occ_q + OW'(1);
            res_valid_q <= 1'b1;
            res_q       <= '{status: ST_OK, item: '0,
                             fill: FILL_W'(occ_q + OW'(1)), last: 1'b1};
            state_q     <= S_IDLE;
          end else begin
            if (is_pop) begin
              occ_q <= occ_q - OW'(1);
            end
            if (cmd_q.func == FN_POP_FRONT) begin
              front_q <= alu_sum;
            end
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          res_valid_q <= 1'b1;
          res_q       <= '{status: ST_OK, item: rdata, fill: FILL_W'(occ_q),
                           last: is_pop || dump_done};
          if (is_pop || dump_done) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q   <= cnt_q + IW'(1);
            addr_q  <= alu_sum;
            state_q <= S_MEM;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/deq_checker.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps

module deq_port_checker
  import deq_pkg::*;
#(
  parameter int Capacity = CAPACITY_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input deq_cmd_t cmd_i,
  input logic     res_valid_o,
  input deq_res_t res_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a start transfer");

  a_result_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result issued with no operation in progress");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> busy)
    else $error("dump stopped before its final value");

  a_flag_zero_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |-> (res_o.item == '0))
    else $error("flagged result carries a non-zero item");

  a_fill_on_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ((res_o.status == ST_EMPTY) || (res_o.status == ST_FULL))) |->
      (res_o.fill == ((res_o.status == ST_EMPTY) ? FILL_W'(0) : FILL_W'(Capacity))))
    else $error("fill disagrees with empty or full status");

endmodule

bind double_ended_queue_top deq_port_checker #(
  .Capacity(CAPACITY)
) u_deq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .cmd_i      (cmd_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
